### design/vpnaq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpnaq_pkg
// Shared types and constants of the void point nearest atom query block.
// ----------------------------------------------------------------------------
package vpnaq_pkg;

	localparam int MAX_ATOMS  = 16384;
	localparam int COORD_BITS = 16;
	localparam int ADDR_BITS  = $clog2(MAX_ATOMS);
	localparam int CNT_BITS   = $clog2(MAX_ATOMS + 1);
	localparam int KIND_BITS  = 3;
	localparam int NUM_KINDS  = 7;
	localparam int RAD_BITS   = 32;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int DSQ_BITS   = SQ_BITS;
	localparam int DIST_BITS  = 33;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [DIST_BITS-1:0] BOX_SQ = DIST_BITS'(1) << (2 * COORD_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  active;
		logic [KIND_BITS-1:0]  kind;
		logic [COORD_BITS-1:0] z;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
	} atom_t;

	typedef struct packed {
		logic                  valid;
		logic                  active;
		logic [KIND_BITS-1:0]  kind;
		logic [DSQ_BITS-1:0]   dsq;
	} dist_res_t;

endpackage

`default_nettype wire

### design/vpnaq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpnaq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vpnaq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/vpnaq_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpnaq_dist
// Shared distance unit: minimum-image squared distance, one atom a cycle,
// three stages (magnitude, square, sum).
// ----------------------------------------------------------------------------
module vpnaq_dist
	import vpnaq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire atom_t                 atom,
	input  wire logic [COORD_BITS-1:0] px,
	input  wire logic [COORD_BITS-1:0] py,
	input  wire logic [COORD_BITS-1:0] pz,
	output      dist_res_t             res,
	output      logic                  busy
);

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  active_s1, active_s2, active_s3;
	logic [KIND_BITS-1:0]  kind_s1, kind_s2, kind_s3;
	logic [COORD_BITS-1:0] mag_s1 [3];
	logic [SQ_BITS-1:0]    sq_s2 [3];
	logic [DSQ_BITS-1:0]   dsq_s3;
	logic [COORD_BITS-1:0] diff [3];

	// wrapping difference; a set sign bit means the other image is nearer
	always_comb begin
		diff[0] = px - atom.x;
		diff[1] = py - atom.y;
		diff[2] = pz - atom.z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			mag_s1[a] <= diff[a][COORD_BITS-1] ? (COORD_BITS'(0) - diff[a]) : diff[a];
			sq_s2[a]  <= SQ_BITS'(mag_s1[a]) * SQ_BITS'(mag_s1[a]);
		end
		active_s1 <= atom.active;
		kind_s1   <= atom.kind;
		active_s2 <= active_s1;
		kind_s2   <= kind_s1;
		active_s3 <= active_s2;
		kind_s3   <= kind_s2;
		// each square is at most 2^(2*COORD_BITS-2), so the sum fits
		dsq_s3    <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	assign res.valid  = valid_s3;
	assign res.active = active_s3;
	assign res.kind   = kind_s3;
	assign res.dsq    = dsq_s3;
	assign busy       = valid_s1 | valid_s2 | valid_s3;

endmodule

`default_nettype wire

### design/void_point_nearest_atom_query.sv
`default_nettype none
// ----------------------------------------------------------------------------
// void_point_nearest_atom_query
// Atom store with a nearest-atom query over a periodic box: a query walks
// every loaded atom through one shared distance unit and reports coverage
// or the minimum squared distance.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake         Payload
// s_*      in   tvalid / tready   tuser: cmd; tdata: x, y, z, kind, active
// m_*      out  tvalid / tready   tdata: covered, min_dist_sq, store_full
// cfg_*    in   cfg_we            cfg_addr: radius index, cfg_wdata: radius^2
//
// In a query, the walk reads one store entry a cycle from the single RAM read
// port, then drains the three-stage distance unit and the RAM read register.
// Reset clears the atom count, the radius registers and all control; the
// store itself is not cleared, as entries above the count are never read.
// Input is taken only while the sequencer is idle and the output register is
// empty or being emptied; a stalled query result holds the sequencer.
//
module void_point_nearest_atom_query
	import vpnaq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [50:48] atom_kind,
	// [51] atom_active, [55:52] zero
	input  wire logic [55:0] s_tdata,
	// [1:0] cmd
	input  wire logic [1:0]  s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [0] covered, [33:1] min_dist_sq, [34] store_full, [39:35] zero
	output      logic [39:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	state_t                state_q, state_d;
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   addr_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic [RAD_BITS-1:0]   radius_q [NUM_KINDS];
	logic                  hit_q;
	logic [DIST_BITS-1:0]  best_q;
	logic                  rd_valid_q;
	logic                  out_valid_q;
	logic                  out_covered_q, out_full_q;
	logic [DIST_BITS-1:0]  out_dist_q;

	logic                  accept;
	logic [1:0]            cmd;
	atom_t                 in_atom;
	atom_t                 rd_atom;
	logic                  store_full;
	logic                  load_we;
	logic                  rd_en;
	logic                  walk_end;
	logic                  pipe_busy;
	logic                  out_free;
	logic                  done_load;
	dist_res_t             dres;
	logic [RAD_BITS-1:0]   dres_rad;

	assign cmd        = s_tuser;
	assign in_atom    = atom_t'(s_tdata[51:0]);
	assign out_free   = !out_valid_q || m_tready;
	assign accept     = s_tvalid && s_tready;
	assign store_full = (count_q == CNT_BITS'(MAX_ATOMS));
	assign load_we    = accept && (cmd == CMD_LOAD) && !store_full;
	assign walk_end   = (addr_q >= count_q);

	// ---- sequencer: next state ---------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_QUERY) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!rd_valid_q && !pipe_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs ------------------------------------------------
	always_comb begin
		s_tready  = 1'b0;
		rd_en     = 1'b0;
		done_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready  = out_free;
			ST_WALK:  rd_en     = !walk_end;
			ST_DRAIN: ;
			ST_DONE:  done_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			addr_q     <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
			best_q     <= BOX_SQ;
			for (int k = 0; k < NUM_KINDS; k++) radius_q[k] <= '0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= rd_en;
			if (cfg_we && cfg_addr < 3'(NUM_KINDS)) begin
				radius_q[cfg_addr] <= cfg_wdata;
			end
			// advance the count on a load, drop it on a clear
			if (load_we) begin
				count_q <= count_q + CNT_BITS'(1);
			end else if (accept && cmd == CMD_CLEAR) begin
				count_q <= '0;
			end
			if (accept && cmd == CMD_QUERY) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
				best_q <= BOX_SQ;
			end else begin
				if (rd_en) addr_q <= addr_q + CNT_BITS'(1);
				// inactive atoms take no part; once covered the minimum is moot
				if (dres.valid && dres.active) begin
					if (DIST_BITS'(dres.dsq) < DIST_BITS'(dres_rad)) hit_q <= 1'b1;
					if (DIST_BITS'(dres.dsq) < best_q) best_q <= DIST_BITS'(dres.dsq);
				end
			end
		end
	end

	// hold the query point for the whole walk
	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_QUERY) begin
			px_q <= in_atom.x;
			py_q <= in_atom.y;
			pz_q <= in_atom.z;
		end
	end

	// type zero has no radius, so it never covers
	always_comb begin
		dres_rad = '0;
		if (dres.kind != '0) dres_rad = radius_q[dres.kind - KIND_BITS'(1)];
	end

	vpnaq_ram #(
		.WIDTH ($bits(atom_t)),
		.DEPTH (MAX_ATOMS)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (count_q[ADDR_BITS-1:0]),
		.wdata (in_atom),
		.re    (rd_en),
		.raddr (addr_q[ADDR_BITS-1:0]),
		.rdata (rd_atom)
	);

	vpnaq_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid_q),
		.atom     (rd_atom),
		.px       (px_q),
		.py       (py_q),
		.pz       (pz_q),
		.res      (dres),
		.busy     (pipe_busy)
	);

	// ---- output register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && cmd == CMD_LOAD) || done_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd == CMD_LOAD) begin
			out_covered_q <= 1'b0;
			out_dist_q    <= '0;
			out_full_q    <= store_full;
		end else if (done_load) begin
			out_covered_q <= hit_q;
			out_dist_q    <= hit_q ? '0 : best_q;
			out_full_q    <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_full_q, out_dist_q, out_covered_q};

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE && !rd_valid_q && !pipe_busy))
		else $error("input taken while a walk is in flight");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(MAX_ATOMS))
		else $error("atom count beyond store depth");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (addr_q < count_q))
		else $error("store read beyond loaded atoms");
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_load |=> (m_tvalid && (m_tdata[33:1] <= BOX_SQ)))
		else $error("query distance above squared box length");
	a_covered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[0] || m_tdata[34])) |-> (m_tdata[33:1] == '0))
		else $error("distance not zero on covered or load result");
`endif

endmodule

`default_nettype wire

### bench/vpnaq_checker.sv
// ----------------------------------------------------------------------------
// vpnaq_checker
// Watches the item, result and register channels of the nearest atom query
// block. Keeps its own atom store and radius table, works out the result of
// every accepted load and query and compares each result field by field.
// ----------------------------------------------------------------------------
module vpnaq_checker
	import vpnaq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [50:48] atom_kind,
	// [51] atom_active, [55:52] zero
	input  wire logic [55:0] s_tdata,
	// [1:0] cmd
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// [0] covered, [33:1] min_dist_sq, [34] store_full, [39:35] zero
	input  wire logic [39:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	output int               waiting,
	output int               failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                 covered;
		logic [DIST_BITS-1:0] min_dist_sq;
		logic                 store_full;
	} answer_t;

	atom_t               atoms [MAX_ATOMS];
	int unsigned         n_atoms = 0;
	// indexed by atom kind; kind zero is never written and keeps radius zero
	logic [RAD_BITS-1:0] radius_sq [NUM_KINDS + 1] = '{default: '0};
	answer_t             owed_answers [$];
	int                  n_bad = 0;

	initial begin
		waiting  = 0;
		failures = 0;
	end

	// squared minimum-image distance along one axis
	function automatic logic [SQ_BITS-1:0] wrap_sq(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		logic [COORD_BITS-1:0] d;
		logic [SQ_BITS-1:0]    mag;
		d = a - b;
		if (d[COORD_BITS-1])
			mag = (SQ_BITS'(1) << COORD_BITS) - SQ_BITS'(d);
		else
			mag = SQ_BITS'(d);
		return mag * mag;
	endfunction

	function automatic answer_t nearest_atom_answer(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py, input logic [COORD_BITS-1:0] pz);
		answer_t              ans;
		logic [DIST_BITS-1:0] dsq;
		logic [DIST_BITS-1:0] best;
		ans  = '0;
		best = BOX_SQ;
		for (int unsigned i = 0; i < n_atoms; i++) begin
			if (!atoms[i].active)
				continue;
			dsq = wrap_sq(px, atoms[i].x) + wrap_sq(py, atoms[i].y) + wrap_sq(pz, atoms[i].z);
			if (dsq < DIST_BITS'(radius_sq[atoms[i].kind])) begin
				ans.covered = 1'b1;
				break;
			end
			if (dsq < best)
				best = dsq;
		end
		if (!ans.covered)
			ans.min_dist_sq = best;
		return ans;
	endfunction

	always @(posedge clk) begin : watch
		answer_t got;
		answer_t want;
		answer_t load_ans;
		if (arst_n) begin
			// results first: an item taken at this edge cannot answer at it
			if (m_tvalid && m_tready) begin
				got.covered     = m_tdata[0];
				got.min_dist_sq = m_tdata[33:1];
				got.store_full  = m_tdata[34];
				if (owed_answers.size() == 0) begin
					$error("result with no item waiting for one: tdata %h", m_tdata);
					n_bad++;
				end else begin
					want = owed_answers.pop_front();
					if (got.covered !== want.covered) begin
						$error("covered: expected %0d, got %0d", want.covered, got.covered);
						n_bad++;
					end
					if (got.min_dist_sq !== want.min_dist_sq) begin
						$error("min_dist_sq: expected %0d, got %0d",
							want.min_dist_sq, got.min_dist_sq);
						n_bad++;
					end
					if (got.store_full !== want.store_full) begin
						$error("store_full: expected %0d, got %0d",
							want.store_full, got.store_full);
						n_bad++;
					end
				end
			end

			if (cfg_we && cfg_addr < NUM_KINDS)
				radius_sq[int'(cfg_addr) + 1] = cfg_wdata;

			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_LOAD: begin
						load_ans = '0;
						if (n_atoms < MAX_ATOMS) begin
							atoms[n_atoms] = atom_t'(s_tdata[51:0]);
							n_atoms++;
						end else begin
							load_ans.store_full = 1'b1;
						end
						owed_answers.push_back(load_ans);
					end
					CMD_QUERY: begin
						owed_answers.push_back(nearest_atom_answer(s_tdata[15:0],
							s_tdata[31:16], s_tdata[47:32]));
					end
					CMD_CLEAR: begin
						n_atoms = 0;
					end
					default: begin
					end
				endcase
			end
		end
		waiting  <= owed_answers.size();
		failures <= n_bad;
	end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the nearest atom query block with loads, queries and clears, at
// random pace on both streams, under several radius tables. A checker beside
// the block predicts every result; this module makes the stimulus, watches
// for a stuck run and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
	import vpnaq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Even a query over a full store fits in the limit several times over.
	localparam int QUIET_LIMIT     = 70000;
	localparam int SETTLE          = 16;
	localparam int LONG_HOLD       = 300;
	localparam int ITEMS_PER_PHASE = 20;
	localparam int STEADY_LOADS    = 8;

	// the block ignores this command value
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum {
		RAD_ZERO,
		RAD_FULL,
		RAD_NEAR,
		RAD_WIDE,
		RAD_STEPPED
	} radius_plan_t;

	typedef enum {
		SINK_OPEN,
		SINK_COIN,
		SINK_SLOW,
		SINK_BUSY
	} sink_mode_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = CMD_LOAD;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_addr  = '0;
	logic [31:0] cfg_wdata = '0;

	int          waiting;
	int          failures;
	int          hold_requests = 0;
	int          burst_left    = 0;
	bit          steady        = 1'b0;
	// positions loaded since the last clear, used to aim queries at atoms
	atom_t       placed [$];

	void_point_nearest_atom_query dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	vpnaq_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.waiting   (waiting),
		.failures  (failures)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one item and hold it until the block takes it. Between bursts,
	// drop valid for a random gap; in steady mode offer back to back.
	task automatic send(input logic [1:0] cmd, input logic [COORD_BITS-1:0] x,
			input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z,
			input logic [KIND_BITS-1:0] kind, input logic active);
		if (!steady && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, active, kind, z, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic load_atom(input atom_t a);
		send(CMD_LOAD, a.x, a.y, a.z, a.kind, a.active);
	endtask

	// kind and active mean nothing to a query or a clear, so randomise them
	task automatic query_at(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic [COORD_BITS-1:0] z);
		send(CMD_QUERY, x, y, z, KIND_BITS'($urandom), 1'($urandom));
	endtask

	task automatic clear_store();
		send(CMD_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom),
			KIND_BITS'($urandom), 1'($urandom));
		placed.delete();
	endtask

	function automatic atom_t random_atom();
		atom_t a;
		a.x      = COORD_BITS'($urandom);
		a.y      = COORD_BITS'($urandom);
		a.z      = COORD_BITS'($urandom);
		// now and then a kind zero atom, which can never cover a point
		a.kind   = ($urandom_range(0, 7) == 0) ? '0 : KIND_BITS'($urandom_range(1, NUM_KINDS));
		a.active = ($urandom_range(0, 3) != 0);
		return a;
	endfunction

	// small signed offset, so a query lands around an atom's radius
	function automatic logic [COORD_BITS-1:0] jitter();
		return COORD_BITS'($urandom_range(0, 2400)) - COORD_BITS'(1200);
	endfunction

	// Stop offering, wait for every owed result, then let the block settle
	// so that a clear still in flight is done before registers change.
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (waiting != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write every radius register, then the spare index beyond the last one,
	// which the block must ignore.
	task automatic set_radii(input radius_plan_t plan);
		logic [RAD_BITS-1:0] v;
		for (int k = 0; k <= NUM_KINDS; k++) begin
			case (plan)
				RAD_ZERO: v = '0;
				RAD_FULL: v = '1;
				RAD_NEAR: v = $urandom_range(0, 4000000);
				RAD_WIDE: v = $urandom;
				default:  v = RAD_BITS'((k + 1) * 250000);
			endcase
			if (k == NUM_KINDS)
				v = $urandom;
			cfg_we    <= 1'b1;
			cfg_addr  <= 3'(k);
			cfg_wdata <= v;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Mostly loads and queries aimed at loaded atoms, with clears to keep the
	// store small, far queries and the odd unused command as noise.
	task automatic random_phase(input int n_items);
		int    done;
		int    pick;
		atom_t a;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				clear_store();
				done++;
			end else if (pick < 40) begin
				a = random_atom();
				load_atom(a);
				placed.push_back(a);
				done++;
			end else if (pick < 85 && placed.size() != 0) begin
				a = placed[$urandom_range(0, placed.size() - 1)];
				query_at(a.x + jitter(), a.y + jitter(), a.z + jitter());
				done++;
			end else if (pick < 96) begin
				query_at(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
				done++;
			end else begin
				send(CMD_UNUSED, COORD_BITS'($urandom), COORD_BITS'($urandom),
					COORD_BITS'($urandom), KIND_BITS'($urandom), 1'($urandom));
			end
		end
	endtask

	// Result side: random stall patterns in segments, plus a long hold-off
	// whenever the stimulus asks for one.
	initial begin : sink
		int         served;
		int         hold_left;
		int         seg_left;
		sink_mode_t mode;
		served    = 0;
		hold_left = 0;
		seg_left  = 0;
		mode      = SINK_OPEN;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && served != hold_requests) begin
				served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					mode     = sink_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(4, 60);
				end
				seg_left--;
				case (mode)
					SINK_OPEN: m_tready <= 1'b1;
					SINK_COIN: m_tready <= ($urandom_range(0, 1) == 1);
					SINK_SLOW: m_tready <= ($urandom_range(0, 4) == 0);
					default:   m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// End the run if nothing moves on either stream for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		atom_t first;
		atom_t a;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one radius per type, stepping up with the type.
		set_radii(RAD_STEPPED);
		// empty store answers with the squared box length
		query_at('0, '0, '0);
		send(CMD_UNUSED, '1, '1, '1, '1, 1'b1);
		load_atom('{active: 1'b1, kind: 3'd1, z: '0, y: '0, x: '0});
		load_atom('{active: 1'b0, kind: 3'd7, z: '1, y: '1, x: '1});
		load_atom('{active: 1'b1, kind: 3'd0, z: 16'h8000, y: 16'h8000, x: 16'h8000});
		load_atom('{active: 1'b1, kind: 3'd4, z: 16'h5555, y: 16'hABCD, x: 16'h1234});
		load_atom('{active: 1'b1, kind: 3'd2, z: 16'h00FF, y: 16'hFF00, x: 16'h0F0F});
		load_atom('{active: 1'b1, kind: 3'd3, z: 16'hF0F0, y: 16'h0FF0, x: 16'hAAAA});
		load_atom('{active: 1'b0, kind: 3'd5, z: 16'h3333, y: 16'hCCCC, x: 16'h7FFF});
		load_atom('{active: 1'b1, kind: 3'd6, z: 16'h7FFF, y: 16'h8001, x: 16'hFFFE});
		// sits on the kind zero atom: distance zero, yet not covered
		query_at(16'h8000, 16'h8000, 16'h8000);
		// exactly half a box away from the atom at the origin on one axis
		query_at(16'h8000, '0, '0);
		// one step across the wrap from the origin atom
		query_at('1, '1, '1);
		query_at(16'h1234 + 16'd300, 16'hABCD - 16'd200, 16'h5555);
		query_at(16'h7FFF, 16'hCCCC, 16'h3333);
		clear_store();
		query_at('0, '0, '0);

		// Random phases under different radius tables.
		drain_and_settle();
		set_radii(RAD_NEAR);
		placed.delete();
		random_phase(ITEMS_PER_PHASE);

		drain_and_settle();
		set_radii(RAD_FULL);
		random_phase(ITEMS_PER_PHASE / 2);
		// hold off the result side while items keep coming, so the block backs up
		hold_requests <= hold_requests + 1;
		random_phase(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);

		drain_and_settle();
		set_radii(RAD_WIDE);
		random_phase(ITEMS_PER_PHASE);

		drain_and_settle();
		set_radii(RAD_NEAR);
		hold_requests <= hold_requests + 1;
		random_phase(ITEMS_PER_PHASE);

		// A back-to-back burst of loads with zero radii, then queries over it.
		drain_and_settle();
		set_radii(RAD_ZERO);
		clear_store();
		steady = 1'b1;
		first  = random_atom();
		load_atom(first);
		repeat (STEADY_LOADS - 1) begin
			a = random_atom();
			load_atom(a);
		end
		steady = 1'b0;
		query_at(first.x + jitter(), first.y + jitter(), first.z + jitter());
		query_at(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
		clear_store();
		a = random_atom();
		load_atom(a);
		query_at(a.x + jitter(), a.y + jitter(), a.z + jitter());

		drain_and_settle();
		@(negedge clk);
		if (failures == 0 && waiting == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
